[rtl/marker_delimited_stream_splitter_macros.svh]
// Assertion macros used by the marker splitter checker.
`ifndef MARKER_DELIMITED_STREAM_SPLITTER_MACROS_SVH
`define MARKER_DELIMITED_STREAM_SPLITTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MDSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MDSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mdss_pkg.sv]
// Constants and helper functions for the marker delimited stream splitter.
package mdss_pkg;

  localparam int IDX_W = 4;
  localparam int LEN_W = 5;
  localparam logic [LEN_W-1:0] MAX_MARKER_LEN = 5'd16;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_START_LOW  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START_HIGH = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_START_LEN  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_END_LOW    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_END_HIGH   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_END_LEN    = 3'd5;

  // Input tuser bit 0.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOI  = 1'b1;

  // Output tuser bit positions.
  localparam int TUSER_CHAN  = 0;
  localparam int TUSER_FLUSH = 1;

  function automatic logic [7:0] marker_byte(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [IDX_W-1:0] idx);
    logic [63:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: 8];
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    if (len == '0) begin
      res = 5'd1;
    end else if (len > MAX_MARKER_LEN) begin
      res = MAX_MARKER_LEN;
    end else begin
      res = len;
    end
    return res;
  endfunction

endpackage

[rtl/marker_delimited_stream_splitter.sv]
// An accepted word's result, if it has one, is in the output register at the next cycle; a
// mismatch first enters the replay state, which then loads the replayed words into that register.
// Throughput: one word per cycle while bytes match or pass straight through and the output
// is not stalled; a mismatch after k held marker bytes replays them and the breaking byte
// through the shared marker byte selector, holding the input off in the replay state.
// Reset (rst_n low, synchronous): plain mode, no partial match, markers zero, lengths one.
module marker_delimited_stream_splitter
  import mdss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]           cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // in_byte
  input  logic [0:0]            in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // out_byte
  output logic [1:0]            out_tuser,  // channel, flush
  output logic                  out_tlast
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REPLAY = 1'b1;

  logic [63:0]      smk_lo_r, smk_hi_r, emk_lo_r, emk_hi_r;
  logic [LEN_W-1:0] slen_r, elen_r;

  logic             state_r, state_nxt;
  logic             mode_r, mode_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] rep_i_r, rep_i_nxt;
  logic [7:0]       hold_r, hold_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_chan_r, out_chan_nxt;
  logic             out_flush_r, out_flush_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_free, in_acc, hit, done;
  logic [63:0]      mk_lo, mk_hi;
  logic [LEN_W-1:0] mk_len;
  logic [IDX_W-1:0] sel_idx;
  logic [7:0]       mk_byte;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign mk_lo  = mode_r ? emk_lo_r : smk_lo_r;
  assign mk_hi  = mode_r ? emk_hi_r : smk_hi_r;
  assign mk_len = clamp_len(mode_r ? elen_r : slen_r);

  // One byte selector serves both the compare and the replay of a held prefix.
  assign sel_idx = (state_r == ST_REPLAY) ? rep_i_r : cnt_r;
  assign mk_byte = marker_byte(mk_lo, mk_hi, sel_idx);
  assign hit     = (in_tdata == mk_byte);
  assign done    = ({1'b0, cnt_r} + 5'd1) >= mk_len;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    rep_i_nxt     = rep_i_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_chan_nxt  = out_chan_r;
    out_flush_nxt = out_flush_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == OP_EOI) begin
            mode_nxt      = 1'b0;
            cnt_nxt       = '0;
            out_valid_nxt = 1'b1;
            out_byte_nxt  = 8'd0;
            out_chan_nxt  = 1'b1;
            out_flush_nxt = 1'b1;
            out_last_nxt  = 1'b1;
          end else if (hit) begin
            if (done) begin
              cnt_nxt  = '0;
              mode_nxt = !mode_r;
              if (mode_r) begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = 8'd0;
                out_chan_nxt  = 1'b1;
                out_flush_nxt = 1'b1;
                out_last_nxt  = 1'b1;
              end
            end else begin
              cnt_nxt = cnt_r + 4'd1;
            end
          end else if (cnt_r == '0) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = in_tdata;
            out_chan_nxt  = mode_r;
            out_flush_nxt = 1'b0;
            out_last_nxt  = 1'b1;
          end else begin
            hold_nxt  = in_tdata;
            rep_i_nxt = '0;
            state_nxt = ST_REPLAY;
          end
        end
      end
      ST_REPLAY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_chan_nxt  = mode_r;
          out_flush_nxt = 1'b0;
          if (rep_i_r != cnt_r) begin
            out_byte_nxt = mk_byte;
            out_last_nxt = 1'b0;
            rep_i_nxt    = rep_i_r + 4'd1;
          end else begin
            out_byte_nxt = hold_r;
            out_last_nxt = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= 1'b0;
      cnt_r       <= '0;
      rep_i_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      rep_i_r     <= rep_i_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r      <= hold_nxt;
    out_byte_r  <= out_byte_nxt;
    out_chan_r  <= out_chan_nxt;
    out_flush_r <= out_flush_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smk_lo_r <= '0;
      smk_hi_r <= '0;
      slen_r   <= 5'd1;
      emk_lo_r <= '0;
      emk_hi_r <= '0;
      elen_r   <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_LOW:  smk_lo_r <= cfg_wdata;
        REG_START_HIGH: smk_hi_r <= cfg_wdata;
        REG_START_LEN:  slen_r   <= cfg_wdata[LEN_W-1:0];
        REG_END_LOW:    emk_lo_r <= cfg_wdata;
        REG_END_HIGH:   emk_hi_r <= cfg_wdata;
        REG_END_LEN:    elen_r   <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_flush_r, out_chan_r};
  assign out_tlast  = out_last_r;

endmodule

[rtl/mdss_checker.sv]
// Port-level checks for the marker delimited stream splitter, bound to the top level.
`include "marker_delimited_stream_splitter_macros.svh"

module mdss_checker
  import mdss_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [0:0] in_tuser,   // operation
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,  // out_byte
  input logic [1:0] out_tuser,  // channel, flush
  input logic       out_tlast
);

  // A stalled result word must not change.
  `MDSS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tuser)
                    && $stable(out_tlast), "stalled result word changed")

  // A flush word carries a zero byte on channel one and closes its item.
  `MDSS_ASSERT_NOW(a_flush_form, out_tvalid && out_tuser[TUSER_FLUSH],
                   out_tdata == 8'd0 && out_tuser[TUSER_CHAN] && out_tlast,
                   "malformed flush word")

  // End of input produces a flush word in the next cycle.
  `MDSS_ASSERT_NEXT(a_eoi_flush, in_tvalid && in_tready && in_tuser[0] == OP_EOI,
                    out_tvalid && out_tuser[TUSER_FLUSH], "end of input gave no flush")

  // A new word is never taken while the output register is stuck.
  `MDSS_ASSERT_NOW(a_no_overrun, in_tready && out_tvalid, out_tready,
                   "input accepted over a stalled result")

endmodule

bind marker_delimited_stream_splitter mdss_checker u_mdss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
